>>> hdl/apph_pkg.sv
package apph_pkg;

    // field widths
    localparam int AUDIO_W   = 24;
    localparam int MOD_W     = 16;
    localparam int FS_W      = 18;
    localparam int CENTER_W  = 12;
    localparam int DEPTH_W   = 11;
    localparam int FB_W      = 11;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int COEF_W    = 24;

    // defaults for the top level parameters
    localparam int STAGES_DEF   = 6;
    localparam int SAMPLE_W_DEF = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK    = 2'd3;

    // register reset values
    localparam logic [FS_W-1:0]     FS_RST     = 18'd48000;
    localparam logic [CENTER_W-1:0] CENTER_RST = 12'd900;
    localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 11'd717;
    localparam logic [FB_W-1:0]     FB_RST     = 11'd0;

    // limits
    localparam logic [FS_W-1:0]     FS_MIN     = 18'd8000;
    localparam logic [FS_W-1:0]     FS_MAX     = 18'd192000;
    localparam logic [CENTER_W-1:0] CENTER_MIN = 12'd20;
    localparam logic [CENTER_W-1:0] CENTER_MAX = 12'd4000;
    localparam logic [DEPTH_W-1:0]  DEPTH_MAX  = 11'd1024;
    localparam logic signed [FB_W-1:0] FB_MAX  = 11'sd870;
    localparam logic signed [FB_W-1:0] FB_MIN  = -11'sd870;

    // frequency path
    localparam int F_W     = 30;
    localparam int FMAX_W  = 33;
    localparam int EXP_W   = 19;
    localparam logic [F_W-1:0]   F_MIN_Q16  = 30'd1310720;
    localparam logic [25:0]      PI_Q24     = 26'd52707179;
    localparam logic signed [19:0] EXP_BIAS = 20'sd131072;
    localparam logic [4:0]       FMAX_DIVISOR = 5'd20;

    // shared multiplier
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 31;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // shared divider
    localparam int DIV_NW = 56;
    localparam int DIV_DW = 40;

    // cordic
    localparam int CORDIC_STEPS = 20;
    localparam int CXY_W        = 32;
    localparam int CZ_W         = 27;

    localparam logic [MUL_B_W-1:0] POW_FRAC [16] = '{
        31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
        31'd1097253708, 31'd1085434105, 31'd1079572136, 31'd1076653033,
        31'd1075196443, 31'd1074468887, 31'd1074105294, 31'd1073923544,
        31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
    };

    localparam logic signed [CZ_W-1:0] ATAN_Q24 [CORDIC_STEPS] = '{
        27'sd13176795, 27'sd7778716, 27'sd4110060, 27'sd2086331, 27'sd1047214,
        27'sd524117, 27'sd262123, 27'sd131069, 27'sd65536, 27'sd32768,
        27'sd16384, 27'sd8192, 27'sd4096, 27'sd2048, 27'sd1024,
        27'sd512, 27'sd256, 27'sd128, 27'sd64, 27'sd32
    };

    typedef struct packed {
        logic                       start;
        logic [FS_W-1:0]            fs;
        logic [CENTER_W-1:0]        center;
        logic [DEPTH_W-1:0]         depth;
        logic signed [MOD_W-1:0]    modulator;
    } t_coef_req;

    typedef struct packed {
        logic                       done;
        logic signed [COEF_W-1:0]   coef;
    } t_coef_rsp;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

endpackage

>>> hdl/apph_ram.sv
module apph_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/apph_div.sv
module apph_div import apph_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_den;

    logic [DIV_DW:0]   trial;
    logic              fits;

    // restoring division, one quotient bit a cycle
    always_comb begin
        trial = {r_rem, r_q[DIV_NW-1]};
        fits  = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= DIV_DW'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DIV_DW-1:0];
            end
            r_q <= {r_q[DIV_NW-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

>>> hdl/apph_coef.sv
module apph_coef import apph_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_coef_req i_req,
    output t_coef_rsp o_rsp
);

    localparam logic [3:0] C_IDLE     = 4'd0;
    localparam logic [3:0] C_FMAX     = 4'd1;
    localparam logic [3:0] C_FMAX_W   = 4'd2;
    localparam logic [3:0] C_POW      = 4'd3;
    localparam logic [3:0] C_POW_RND  = 4'd4;
    localparam logic [3:0] C_FREQ     = 4'd5;
    localparam logic [3:0] C_CLAMP    = 4'd6;
    localparam logic [3:0] C_WMUL     = 4'd7;
    localparam logic [3:0] C_WDIV     = 4'd8;
    localparam logic [3:0] C_WDIV_W   = 4'd9;
    localparam logic [3:0] C_CORDIC   = 4'd10;
    localparam logic [3:0] C_CDIV     = 4'd11;
    localparam logic [3:0] C_CDIV_W   = 4'd12;

    localparam logic [3:0] K_LAST = 4'd15;
    localparam logic [4:0] I_LAST = 5'(CORDIC_STEPS - 1);

    // ceil(2^24 / 5), exact quotient by five for operands below 2^21
    localparam logic [21:0] RECIP_5 = 22'd3355444;

    logic [3:0]                r_state;
    logic [FS_W-1:0]           r_fs;
    logic [CENTER_W-1:0]       r_center;
    logic [EXP_W-1:0]          r_eo;
    logic [3:0]                r_k;
    logic [MUL_A_W-1:0]        r_r;
    logic [MUL_P_W-1:0]        r_prod;
    logic [FMAX_W-1:0]         r_fmax;
    logic [F_W-1:0]            r_f;
    logic signed [CXY_W-1:0]   r_x;
    logic signed [CXY_W-1:0]   r_y;
    logic signed [CZ_W-1:0]    r_z;
    logic [4:0]                r_i;
    logic                      r_neg;
    logic                      r_done;
    logic signed [COEF_W-1:0]  r_coef;

    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic [MUL_P_W-1:0]        mul_p;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    logic [FS_W-1:0]           fs_cl;
    logic [DEPTH_W-1:0]        depth_cl;
    logic signed [27:0]        exp_prod;
    logic signed [19:0]        exp_off;
    logic [16:0]               cmax_raw;
    logic [CENTER_W-1:0]       cmax;
    logic [CENTER_W-1:0]       center_cl;
    logic [15:0]               frac;
    logic [MUL_A_W+3:0]        pow_sh;
    logic [19:0]               pow_q16;
    logic [MUL_P_W-1:0]        rnd;
    logic [F_W-1:0]            f_raw;
    logic [F_W-1:0]            f_lo;
    logic [21:0]               fs9;
    logic [43:0]               fs9_prod;
    logic [19:0]               fs9_q;
    logic [21:0]               fs9_r;
    logic [13:0]               rem_frac;
    logic [FMAX_W-1:0]         fmax_calc;
    logic signed [CXY_W-1:0]   dx;
    logic signed [CXY_W-1:0]   dy;
    logic signed [CXY_W:0]     den_s;
    logic signed [CXY_W:0]     dif_s;
    logic [CXY_W:0]            dif_mag;
    logic [COEF_W-1:0]         q_mag;

    always_comb begin
        fs_cl = i_req.fs;
        if (i_req.fs < FS_MIN) begin
            fs_cl = FS_MIN;
        end else if (i_req.fs > FS_MAX) begin
            fs_cl = FS_MAX;
        end
        depth_cl = (i_req.depth > DEPTH_MAX) ? DEPTH_MAX : i_req.depth;
        exp_prod = 28'(signed'({1'b0, depth_cl})) * 28'(i_req.modulator);
        exp_off  = exp_prod[27:8] + EXP_BIAS;

        // fmax = fs*9*2^16/20 = (fs*9/5)*2^14 plus the remainder's share
        fs9      = 22'(r_fs) * 22'd9;
        fs9_prod = 44'(fs9) * 44'(RECIP_5);
        fs9_q    = fs9_prod[43:24];
        fs9_r    = fs9 - 22'(fs9_q) * 22'd5;
        case (fs9_r)
            22'd1:   rem_frac = 14'd3276;
            22'd2:   rem_frac = 14'd6553;
            22'd3:   rem_frac = 14'd9830;
            22'd4:   rem_frac = 14'd13107;
            default: rem_frac = 14'd0;
        endcase
        fmax_calc = FMAX_W'({fs9_q, 14'b0}) + FMAX_W'(rem_frac);

        cmax_raw  = r_fmax[32:16];
        cmax      = (cmax_raw > 17'(CENTER_MAX)) ? CENTER_MAX : cmax_raw[CENTER_W-1:0];
        center_cl = (r_center < CENTER_MIN) ? CENTER_MIN : r_center;
        if (center_cl > cmax) begin
            center_cl = cmax;
        end

        frac    = r_eo[15:0];
        pow_sh  = {4'b0, r_r} << r_eo[18:16];
        pow_q16 = pow_sh[MUL_A_W+3:16];
        rnd     = r_prod + MUL_P_W'(64'd1 << 29);

        f_raw = r_prod[F_W-1:0];
        f_lo  = (f_raw < F_MIN_Q16) ? F_MIN_Q16 : f_raw;

        dx = r_y >>> r_i;
        dy = r_x >>> r_i;

        den_s   = (CXY_W+1)'(r_y) + (CXY_W+1)'(r_x);
        dif_s   = (CXY_W+1)'(r_y) - (CXY_W+1)'(r_x);
        dif_mag = dif_s[CXY_W] ? (CXY_W+1)'(-dif_s) : dif_s;
        q_mag   = div_rsp.quo[COEF_W-1:0];
    end

    // one multiplier shared by the exponent, frequency and angle steps
    always_comb begin
        case (r_state)
            C_FREQ: begin
                mul_a = MUL_A_W'(pow_q16);
                mul_b = MUL_B_W'(r_center);
            end
            C_WMUL: begin
                mul_a = MUL_A_W'(r_f);
                mul_b = MUL_B_W'(PI_Q24);
            end
            default: begin
                mul_a = r_r;
                mul_b = POW_FRAC[r_k];
            end
        endcase
        mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        case (r_state)
            C_WDIV: begin
                div_req.start = 1'b1;
                div_req.num   = r_prod[DIV_NW-1:0];
                div_req.den   = DIV_DW'({r_fs, 16'b0});
            end
            C_CDIV: begin
                div_req.start = den_s > 0;
                div_req.num   = DIV_NW'({dif_mag, 22'b0});
                div_req.den   = DIV_DW'(den_s);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    apph_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_state <= C_FMAX;
                    end
                end
                C_FMAX: begin
                    r_state <= C_FMAX_W;
                end
                C_FMAX_W: begin
                    r_state <= C_POW;
                end
                C_POW: begin
                    if (frac[K_LAST - r_k]) begin
                        r_state <= C_POW_RND;
                    end else if (r_k == K_LAST) begin
                        r_state <= C_FREQ;
                    end
                end
                C_POW_RND: begin
                    r_state <= (r_k == K_LAST) ? C_FREQ : C_POW;
                end
                C_FREQ: begin
                    r_state <= C_CLAMP;
                end
                C_CLAMP: begin
                    r_state <= C_WMUL;
                end
                C_WMUL: begin
                    r_state <= C_WDIV;
                end
                C_WDIV: begin
                    r_state <= C_WDIV_W;
                end
                C_WDIV_W: begin
                    if (div_rsp.done) begin
                        r_state <= C_CORDIC;
                    end
                end
                C_CORDIC: begin
                    if (r_i == I_LAST) begin
                        r_state <= C_CDIV;
                    end
                end
                C_CDIV: begin
                    if (den_s > 0) begin
                        r_state <= C_CDIV_W;
                    end else begin
                        r_state <= C_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                C_CDIV_W: begin
                    if (div_rsp.done) begin
                        r_state <= C_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                r_fs     <= fs_cl;
                r_center <= i_req.center;
                r_eo     <= exp_off[EXP_W-1:0];
            end
            C_FMAX: begin
                r_fmax <= fmax_calc;
            end
            C_FMAX_W: begin
                r_center <= center_cl;
                r_r      <= MUL_A_W'(64'd1 << 30);
                r_k      <= '0;
            end
            C_POW: begin
                r_prod <= mul_p;
                if (!frac[K_LAST - r_k] && r_k != K_LAST) begin
                    r_k <= r_k + 1'b1;
                end
            end
            C_POW_RND: begin
                r_r <= rnd[MUL_A_W+29:30];
                if (r_k != K_LAST) begin
                    r_k <= r_k + 1'b1;
                end
            end
            C_FREQ, C_WMUL: begin
                r_prod <= mul_p;
            end
            C_CLAMP: begin
                r_f <= (FMAX_W'(f_lo) > r_fmax) ? r_fmax[F_W-1:0] : f_lo;
            end
            C_WDIV_W: begin
                r_z <= signed'(div_rsp.quo[CZ_W-1:0]);
                r_x <= CXY_W'(64'd1 << 28);
                r_y <= '0;
                r_i <= '0;
            end
            C_CORDIC: begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - ATAN_Q24[r_i];
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + ATAN_Q24[r_i];
                end
                r_i <= r_i + 1'b1;
            end
            C_CDIV: begin
                r_neg <= dif_s[CXY_W];
                if (!(den_s > 0)) begin
                    r_coef <= -COEF_W'(32'sd4194304);
                end
            end
            C_CDIV_W: begin
                r_coef <= r_neg ? -signed'(q_mag) : signed'(q_mag);
            end
            default: begin
                r_i <= r_i;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.coef = r_coef;

endmodule

>>> hdl/allpass_phaser_with_feedback.sv
// six-section first-order allpass phaser with feedback. each transaction on the input
// channel carries one audio sample (signed q1.23) and one lfo sample (signed q1.15);
// each yields exactly one saturated q1.23 sample on the output channel. the lfo moves
// the sweep frequency around center_hz by up to two octaves times depth, clamped to
// 20 hz .. 0.45 fs, and the last section's output is fed back to the input scaled by
// feedback_q10. from acceptance to the result being offered the coefficient path
// dominates: it waits on the single one-bit-per-cycle divider for the angle and, when
// the cordic sum x+y is positive, for the coefficient ratio, and it runs the fractional
// power steps, 20 cordic iterations and its set-up states; then each section passes
// over the history memory in its read-x, read-y, multiply and accumulate states, and the
// output is loaded. the input is taken only while idle, so the next transaction can be
// accepted in the same cycle that a result is offered; a finished result sits in the
// output register so the next transaction can be accepted while it waits, and a further
// result holds the sequencer until that register frees up.
// configuration writes are applied at once and belong in idle periods only.
module allpass_phaser_with_feedback import apph_pkg::*; #(
    parameter int STAGES       = STAGES_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [AUDIO_W-1:0]   i_audio_in,
    input  logic signed [MOD_W-1:0]     i_modulator_in,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [AUDIO_W-1:0]   o_audio_out
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int HDEPTH = 2 * STAGES;
    localparam int HA_W   = $clog2(HDEPTH);
    localparam int ST_W   = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int PW     = SW + COEF_W + 1;   // section product
    localparam int YW     = SW + 4;            // section sum before saturation
    localparam int FPW    = SW + FB_W;         // feedback product
    localparam int IW     = SW + 12;           // input sum before saturation

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_COEF = 3'd1;
    localparam logic [2:0] T_RD_X = 3'd2;
    localparam logic [2:0] T_RD_Y = 3'd3;
    localparam logic [2:0] T_MUL  = 3'd4;
    localparam logic [2:0] T_ACC  = 3'd5;
    localparam logic [2:0] T_OUT  = 3'd6;

    // configuration registers
    logic [FS_W-1:0]           r_fs;
    logic [CENTER_W-1:0]       r_center;
    logic [DEPTH_W-1:0]        r_depth;
    logic signed [FB_W-1:0]    r_fb;

    // sequencer and datapath registers
    logic [2:0]                r_state;
    logic [ST_W-1:0]           r_st;
    logic [HDEPTH-1:0]         r_hvalid;
    logic signed [MOD_W-1:0]   r_mod;
    logic signed [COEF_W-1:0]  r_c;
    logic signed [SW-1:0]      r_s;
    logic signed [SW-1:0]      r_x1;
    logic signed [PW-1:0]      r_prod;
    logic signed [SW-1:0]      r_fbv;
    logic                      r_out_valid;
    logic signed [AUDIO_W-1:0] r_out;

    t_coef_req                 coef_req;
    t_coef_rsp                 coef_rsp;

    logic                      in_acc;
    logic [HA_W-1:0]           addr_x;
    logic [HA_W-1:0]           addr_y;
    logic [HA_W-1:0]           rd_addr;
    logic                      wr_en;
    logic [HA_W-1:0]           wr_addr;
    logic [SW-1:0]             wr_data;
    logic [SW-1:0]             rd_data;
    logic signed [SW-1:0]      hist_x;
    logic signed [SW-1:0]      hist_y;
    logic signed [SW:0]        diff;
    logic signed [PW-1:0]      prod_n;
    logic signed [PW-1:0]      prod_rnd;
    logic signed [YW-1:0]      y_wide;
    logic signed [SW-1:0]      y_sat;
    logic signed [FB_W-1:0]    fb_cl;
    logic signed [FPW-1:0]     fb_prod;
    logic signed [IW-1:0]      in_wide;
    logic signed [SW-1:0]      in_sat;
    logic signed [SW+AUDIO_W-1:0] out_ext;
    logic                      out_load;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == T_IDLE);
    assign out_load   = (r_state == T_OUT) && (!r_out_valid || i_out_ready);

    // even entry keeps a section's last input, odd entry its last output
    assign addr_x = HA_W'({r_st, 1'b0});
    assign addr_y = HA_W'({r_st, 1'b1});

    // entries never written since reset read as zero
    assign hist_x = r_hvalid[addr_x] ? signed'(rd_data) : '0;
    assign hist_y = r_hvalid[addr_y] ? signed'(rd_data) : '0;

    // section: y = c*(x - y1) + x1, rounded and saturated
    always_comb begin
        diff     = (SW+1)'(r_s) - (SW+1)'(hist_y);
        prod_n   = PW'(r_c) * PW'(diff);
        prod_rnd = r_prod + PW'(64'sd2097152);
        y_wide   = YW'(signed'(prod_rnd[PW-1:22])) + YW'(r_x1);
        if ((&y_wide[YW-1:SW-1]) || !(|y_wide[YW-1:SW-1])) begin
            y_sat = y_wide[SW-1:0];
        end else begin
            y_sat = y_wide[YW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
    end

    // input plus scaled feedback, saturated
    always_comb begin
        fb_cl = r_fb;
        if (r_fb > FB_MAX) begin
            fb_cl = FB_MAX;
        end else if (r_fb < FB_MIN) begin
            fb_cl = FB_MIN;
        end
        fb_prod = FPW'(fb_cl) * FPW'(r_fbv);
        in_wide = IW'(i_audio_in) + IW'(signed'(fb_prod[FPW-1:10]));
        if ((&in_wide[IW-1:SW-1]) || !(|in_wide[IW-1:SW-1])) begin
            in_sat = in_wide[SW-1:0];
        end else begin
            in_sat = in_wide[IW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
    end

    // history memory port control
    always_comb begin
        rd_addr = (r_state == T_RD_Y) ? addr_y : addr_x;
        wr_en   = (r_state == T_MUL) || (r_state == T_ACC);
        wr_addr = (r_state == T_ACC) ? addr_y : addr_x;
        wr_data = (r_state == T_ACC) ? y_sat : r_s;
    end

    apph_ram #(
        .WIDTH (SW),
        .DEPTH (HDEPTH)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // coefficient unit, started when a transaction is accepted
    always_comb begin
        coef_req.start     = in_acc;
        coef_req.fs        = r_fs;
        coef_req.center    = r_center;
        coef_req.depth     = r_depth;
        coef_req.modulator = in_acc ? i_modulator_in : r_mod;
    end

    apph_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (coef_req),
        .o_rsp   (coef_rsp)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs     <= FS_RST;
            r_center <= CENTER_RST;
            r_depth  <= DEPTH_RST;
            r_fb     <= FB_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SAMPLE_RATE: r_fs     <= i_cfg_data[FS_W-1:0];
                REG_CENTER:      r_center <= i_cfg_data[CENTER_W-1:0];
                REG_DEPTH:       r_depth  <= i_cfg_data[DEPTH_W-1:0];
                REG_FEEDBACK:    r_fb     <= signed'(i_cfg_data[FB_W-1:0]);
                default:         r_fs     <= r_fs;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_st        <= '0;
            r_hvalid    <= '0;
            r_fbv       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                T_IDLE: begin
                    if (in_acc) begin
                        r_state <= T_COEF;
                    end
                end
                T_COEF: begin
                    if (coef_rsp.done) begin
                        r_st    <= '0;
                        r_state <= T_RD_X;
                    end
                end
                T_RD_X: begin
                    r_state <= T_RD_Y;
                end
                T_RD_Y: begin
                    r_state <= T_MUL;
                end
                T_MUL: begin
                    r_hvalid[addr_x] <= 1'b1;
                    r_state          <= T_ACC;
                end
                T_ACC: begin
                    r_hvalid[addr_y] <= 1'b1;
                    if (r_st == ST_W'(STAGES - 1)) begin
                        r_state <= T_OUT;
                    end else begin
                        r_st    <= r_st + 1'b1;
                        r_state <= T_RD_X;
                    end
                end
                T_OUT: begin
                    if (out_load) begin
                        r_fbv   <= r_s;
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
            // a new result replaces one taken in the same cycle
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mod <= i_modulator_in;
            r_s   <= in_sat;
        end
        if (coef_rsp.done) begin
            r_c <= coef_rsp.coef;
        end
        if (r_state == T_RD_Y) begin
            r_x1 <= hist_x;
        end
        if (r_state == T_MUL) begin
            r_prod <= prod_n;
        end
        if (r_state == T_ACC) begin
            r_s <= y_sat;
        end
        if (out_load) begin
            r_out <= out_ext[AUDIO_W-1:0];
        end
    end

    // low 24 bits of the sign-extended sample
    assign out_ext = (SW+AUDIO_W)'(r_s);

    assign o_out_valid = r_out_valid;
    assign o_audio_out = r_out;

endmodule
